/* hdl/adsr_pkg.sv */
// shared types and constants for the adsr envelope stepper
`default_nettype none

package adsr_pkg;

    localparam int LEVEL_W   = 17;
    localparam int TIME_W    = 24;
    localparam int RATE_W    = 17;
    localparam int PROD_W    = TIME_W + RATE_W;
    localparam int FRAC_W    = 16;
    localparam int TICK_W    = PROD_W - FRAC_W;
    localparam int DIV_STEPS = LEVEL_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 17'd65536;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        STAGE_IDLE    = 3'd0,
        STAGE_ATTACK  = 3'd1,
        STAGE_DECAY   = 3'd2,
        STAGE_SUSTAIN = 3'd3,
        STAGE_RELEASE = 3'd4
    } stage_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [TIME_W-1:0]  attack_time;
        logic [TIME_W-1:0]  decay_time;
        logic [LEVEL_W-1:0] sustain_level;
        logic [TIME_W-1:0]  release_time;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] env_level;
        logic [2:0]         env_stage;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic mul;
        logic div_init;
        logic div_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_step;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* hdl/adsr_ctrl.sv */
// sequencer for one item: capture, multiply, divide when a step is needed, commit
`default_nettype none

module adsr_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  adsr_pkg::dp_status_t status,
    output adsr_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DINIT,
        ST_DIV,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = status.need_step ? ST_DINIT : ST_COMMIT;
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // wait for the output register to free up
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/adsr_dp.sv */
// datapath: item capture, tick multiply, step divider, envelope update, output register
`default_nettype none

module adsr_dp #(
    parameter int CONTROL_RATE = 735
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  adsr_pkg::in_item_t   s_data,
    input  adsr_pkg::ctrl_cmd_t  cmd,
    output adsr_pkg::dp_status_t status,
    output logic                 m_valid,
    input  wire                  m_ready,
    output adsr_pkg::out_item_t  m_data
);

    localparam int LW = adsr_pkg::LEVEL_W;
    localparam logic [adsr_pkg::RATE_W-1:0] RATE = adsr_pkg::RATE_W'(CONTROL_RATE);

    adsr_pkg::in_item_t  item_reg;
    logic [LW-1:0]       sus_reg;
    logic [adsr_pkg::PROD_W-1:0] product_reg;
    logic [LW-1:0]       divisor_reg;
    logic                big_reg;
    logic [LW-1:0]       rem_reg;
    logic [LW-1:0]       quo_reg;
    logic [adsr_pkg::CNT_W-1:0] cnt_reg;
    adsr_pkg::stage_t    stage_reg;
    adsr_pkg::stage_t    stage_next;
    logic [LW-1:0]       level_reg;
    logic [LW-1:0]       level_next;
    logic                out_valid_reg;
    adsr_pkg::out_item_t out_reg;

    logic [adsr_pkg::TIME_W-1:0] time_sel;
    logic [adsr_pkg::TICK_W-1:0] ticks;
    logic                        ticks_big;
    logic [LW:0]                 trial;
    logic                        trial_ge;
    logic [LW:0]                 trial_diff;
    logic [LW-1:0]               step;
    logic [LW:0]                 add_sum;
    logic signed [LW+1:0]        sub_diff;

    // time knob for the current stage
    always_comb begin
        case (stage_reg)
            adsr_pkg::STAGE_DECAY:   time_sel = item_reg.decay_time;
            adsr_pkg::STAGE_RELEASE: time_sel = item_reg.release_time;
            default:                 time_sel = item_reg.attack_time;
        endcase
    end

    assign ticks     = product_reg[adsr_pkg::PROD_W-1:adsr_pkg::FRAC_W];
    assign ticks_big = ticks > adsr_pkg::TICK_W'(adsr_pkg::FULL_SCALE);

    // restoring divider, one quotient bit per cycle
    assign trial      = {rem_reg, quo_reg[LW-1]};
    assign trial_ge   = trial >= {1'b0, divisor_reg};
    assign trial_diff = trial - {1'b0, divisor_reg};

    // more ticks than full scale means a zero quotient, floored to one
    assign step = big_reg ? LW'(1) : quo_reg;

    assign add_sum  = {1'b0, level_reg} + {1'b0, step};
    assign sub_diff = $signed({2'b00, level_reg}) - $signed({2'b00, step});

    always_comb begin
        stage_next = stage_reg;
        level_next = level_reg;
        case (item_reg.opcode)
            adsr_pkg::OP_NOTE_ON:  stage_next = adsr_pkg::STAGE_ATTACK;
            adsr_pkg::OP_NOTE_OFF: stage_next = adsr_pkg::STAGE_RELEASE;
            adsr_pkg::OP_TICK: begin
                case (stage_reg)
                    adsr_pkg::STAGE_ATTACK: begin
                        if (add_sum >= {1'b0, adsr_pkg::FULL_SCALE}) begin
                            level_next = adsr_pkg::FULL_SCALE;
                            stage_next = adsr_pkg::STAGE_DECAY;
                        end else begin
                            level_next = add_sum[LW-1:0];
                        end
                    end
                    adsr_pkg::STAGE_DECAY: begin
                        if (sub_diff <= $signed({2'b00, sus_reg})) begin
                            level_next = sus_reg;
                            stage_next = adsr_pkg::STAGE_SUSTAIN;
                        end else begin
                            level_next = sub_diff[LW-1:0];
                        end
                    end
                    adsr_pkg::STAGE_SUSTAIN: level_next = sus_reg;
                    adsr_pkg::STAGE_RELEASE: begin
                        if (sub_diff <= (LW+2)'(0)) begin
                            level_next = '0;
                            stage_next = adsr_pkg::STAGE_IDLE;
                        end else begin
                            level_next = sub_diff[LW-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign status.need_step = (item_reg.opcode == adsr_pkg::OP_TICK)
                            && (stage_reg == adsr_pkg::STAGE_ATTACK
                             || stage_reg == adsr_pkg::STAGE_DECAY
                             || stage_reg == adsr_pkg::STAGE_RELEASE);
    assign status.div_last  = (cnt_reg == adsr_pkg::CNT_W'(adsr_pkg::DIV_STEPS - 1));
    assign status.out_free  = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
            sus_reg  <= (s_data.sustain_level > adsr_pkg::FULL_SCALE)
                      ? adsr_pkg::FULL_SCALE : s_data.sustain_level;
        end
        if (cmd.mul) begin
            product_reg <= {{adsr_pkg::RATE_W{1'b0}}, time_sel}
                         * {{adsr_pkg::TIME_W{1'b0}}, RATE};
        end
        if (cmd.div_init) begin
            big_reg     <= ticks_big;
            divisor_reg <= (ticks == '0 || ticks_big) ? LW'(1) : ticks[LW-1:0];
            rem_reg     <= '0;
            quo_reg     <= adsr_pkg::FULL_SCALE;
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_diff[LW-1:0] : trial[LW-1:0];
            quo_reg <= {quo_reg[LW-2:0], trial_ge};
        end
        if (cmd.commit) begin
            out_reg.env_level <= level_next;
            out_reg.env_stage <= stage_next;
        end
    end

    // control and envelope state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            stage_reg     <= adsr_pkg::STAGE_IDLE;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.div_init) begin
                cnt_reg <= '0;
            end else if (cmd.div_step) begin
                cnt_reg <= cnt_reg + adsr_pkg::CNT_W'(1);
            end
            if (cmd.commit) begin
                stage_reg     <= stage_next;
                level_reg     <= level_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/adsr_envelope_stepper.sv */
// top level of the rate based adsr envelope stepper
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------------------
//   s_      | in  | s_valid / s_ready  | opcode, attack/decay/release time, sustain
//   m_      | out | m_valid / m_ready  | env_level, env_stage
//
// a control tick in attack, decay or release passes from accept to result through
// capture, multiply, divider setup, the bit-serial step divider and commit.
// note events, idle and sustain ticks go through capture, multiply and commit only.
// one item at a time; the next item is accepted once the current one is committed,
// even while its result still waits in the output register.
// synchronous active-low reset, no clearing pass.
`default_nettype none

module adsr_envelope_stepper #(
    parameter int CONTROL_RATE = 735
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  adsr_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output adsr_pkg::out_item_t m_data
);

    adsr_pkg::ctrl_cmd_t  cmd;
    adsr_pkg::dp_status_t status;

    adsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    adsr_dp #(
        .CONTROL_RATE (CONTROL_RATE)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

/* hdl/adsr_checker.sv */
// port-level checks for the adsr envelope stepper and their bind
`default_nettype none

module adsr_checker (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_valid,
    input wire                 s_ready,
    input wire                 m_valid,
    input wire                 m_ready,
    input adsr_pkg::out_item_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // only one item in flight
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after accept");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.env_level <= adsr_pkg::FULL_SCALE)
        else $error("envelope level above full scale");

    // idle is only reached with the level at zero
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.env_stage == adsr_pkg::STAGE_IDLE |-> m_data.env_level == '0)
        else $error("idle stage with nonzero level");

endmodule

bind adsr_envelope_stepper adsr_checker u_adsr_checker (.*);

`default_nettype wire
